// File: hw/rtl/dmwc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmwc_pkg
// Shared codes and types for the direct-mapped instruction/data cache.
// ----------------------------------------------------------------------------
package dmwc_pkg;

  localparam int ADDR_W  = 32;
  localparam int DATA_W  = 64;
  localparam int CMD_W   = 3;
  localparam int SIZE_W  = 4;
  localparam int OSIZE_W = 7;
  localparam int KIND_W  = 2;

  // request commands
  localparam logic [CMD_W-1:0] CMD_FETCH = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_STORE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PEEK  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_COH   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_FLUSH = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RESP  = 3'd6;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_RDATA = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DONE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RDREQ = 2'd2;
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd3;

  // what a memory response is expected for
  localparam logic [2:0] WK_NONE  = 3'd0;
  localparam logic [2:0] WK_IFILL = 3'd1;
  localparam logic [2:0] WK_DFILL = 3'd2;
  localparam logic [2:0] WK_UNC   = 3'd3;
  localparam logic [2:0] WK_PEEK  = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [ADDR_W-1:0]  addr;
    logic [OSIZE_W-1:0] size;
    logic [DATA_W-1:0]  data;
    logic               hit;
    logic               last;
  } result_t;

endpackage

// File: hw/rtl/dmwc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmwc_ram
// Generic one-write one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dmwc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/direct_mapped_writeback_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direct_mapped_writeback_cache
// Direct-mapped read-only icache and write-back write-allocate dcache with a
// byte-serial sequencer over the tag and word RAMs.
// ----------------------------------------------------------------------------
// a cached hit checks the tag RAM for each touched line (S_LRD, S_LCMP), then
//   reads each byte through the word RAM read port (S_ARD, S_AOP)
// a dirty victim is written back word by word first; misses then wait on memory
// one request at a time; ready again in idle or while a response is awaited
// reset clears valid and dirty flops at once, no clearing pass
// ----------------------------------------------------------------------------
module direct_mapped_writeback_cache #(
  parameter int LINE_BYTES   = 16,
  parameter int ICACHE_LINES = 64,
  parameter int DCACHE_LINES = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [dmwc_pkg::CMD_W-1:0]       in_command,
  input  logic [dmwc_pkg::ADDR_W-1:0]      in_address,
  input  logic [dmwc_pkg::SIZE_W-1:0]      in_size_bytes,
  input  logic [dmwc_pkg::DATA_W-1:0]      in_write_data,
  input  logic [dmwc_pkg::DATA_W-1:0]      in_mem_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [dmwc_pkg::KIND_W-1:0]      out_kind,
  output logic [dmwc_pkg::ADDR_W-1:0]      out_address,
  output logic [dmwc_pkg::OSIZE_W-1:0]     out_size,
  output logic [dmwc_pkg::DATA_W-1:0]      out_data,
  output logic                             out_all_hit,
  output logic                             out_last,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import dmwc_pkg::*;

  localparam int OFF_W   = $clog2(LINE_BYTES);
  localparam int WPL     = LINE_BYTES / 8;
  localparam int CNT_W   = $clog2(WPL + 1);
  localparam int IIDX_W  = $clog2(ICACHE_LINES);
  localparam int DIDX_W  = $clog2(DCACHE_LINES);
  localparam int ITAG_W  = ADDR_W - OFF_W - IIDX_W;
  localparam int DTAG_W  = ADDR_W - OFF_W - DIDX_W;
  localparam int IWA_W   = IIDX_W + OFF_W - 3;
  localparam int DWA_W   = DIDX_W + OFF_W - 3;
  localparam int IWORDS  = ICACHE_LINES * WPL;
  localparam int DWORDS  = DCACHE_LINES * WPL;
  localparam logic [ADDR_W-1:0] LINE_MASK = ADDR_W'(LINE_BYTES - 1);
  localparam logic [CNT_W-1:0]  LAST_WORD = CNT_W'(WPL - 1);

  localparam logic REG_LO = 1'b0;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_CHK  = 5'd1;
  localparam logic [4:0] S_UREQ = 5'd2;
  localparam logic [4:0] S_UWR  = 5'd3;
  localparam logic [4:0] S_LRD  = 5'd4;
  localparam logic [4:0] S_LCMP = 5'd5;
  localparam logic [4:0] S_MREQ = 5'd6;
  localparam logic [4:0] S_WBRD = 5'd7;
  localparam logic [4:0] S_WBEM = 5'd8;
  localparam logic [4:0] S_ARD  = 5'd9;
  localparam logic [4:0] S_AOP  = 5'd10;
  localparam logic [4:0] S_PRD  = 5'd11;
  localparam logic [4:0] S_POP  = 5'd12;
  localparam logic [4:0] S_CRD  = 5'd13;
  localparam logic [4:0] S_COP  = 5'd14;
  localparam logic [4:0] S_FRD  = 5'd15;
  localparam logic [4:0] S_FCHK = 5'd16;
  localparam logic [4:0] S_FIN  = 5'd17;
  localparam logic [4:0] S_WAIT = 5'd18;

  function automatic logic [IIDX_W-1:0] iidx_f(input logic [ADDR_W-1:0] x);
    return IIDX_W'(x >> OFF_W);
  endfunction
  function automatic logic [DIDX_W-1:0] didx_f(input logic [ADDR_W-1:0] x);
    return DIDX_W'(x >> OFF_W);
  endfunction
  function automatic logic [ITAG_W-1:0] itag_f(input logic [ADDR_W-1:0] x);
    return ITAG_W'(x >> (OFF_W + IIDX_W));
  endfunction
  function automatic logic [DTAG_W-1:0] dtag_f(input logic [ADDR_W-1:0] x);
    return DTAG_W'(x >> (OFF_W + DIDX_W));
  endfunction
  function automatic logic [IWA_W-1:0] iwa_f(input logic [ADDR_W-1:0] x);
    return IWA_W'(x >> 3);
  endfunction
  function automatic logic [DWA_W-1:0] dwa_f(input logic [ADDR_W-1:0] x);
    return DWA_W'(x >> 3);
  endfunction

  // control and request state
  logic [4:0]         state_r, state_nxt;
  logic [CMD_W-1:0]   cmd_r, cmd_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [SIZE_W-1:0]  sz_r, sz_nxt;
  logic [DATA_W-1:0]  data_r, data_nxt;
  logic [SIZE_W-1:0]  pos_r, pos_nxt;
  logic               miss_r, miss_nxt;
  logic               sel_r, sel_nxt;
  logic [2:0]         wk_r, wk_nxt;
  logic [CNT_W-1:0]   wcnt_r, wcnt_nxt;
  logic [DIDX_W-1:0]  vidx_r, vidx_nxt;
  logic [DTAG_W-1:0]  vtag_r, vtag_nxt;
  logic [ADDR_W-1:0]  lo_r, hi_r;

  logic [ICACHE_LINES-1:0] ivalid_r;
  logic [DCACHE_LINES-1:0] dvalid_r, ddirty_r;

  logic               out_valid_r;
  result_t            res_r, res;
  logic               emit;
  logic               out_free;
  logic               acc_in;

  // valid and dirty updates
  logic               iv_we, iv_val, dv_we, dv_val, dd_we, dd_val;
  logic [IIDX_W-1:0]  iv_idx;
  logic [DIDX_W-1:0]  dv_idx, dd_idx;

  // ram ports
  logic               itag_we, dtag_we, iw_we, dw_we;
  logic [IIDX_W-1:0]  itag_raddr;
  logic [DIDX_W-1:0]  dtag_raddr;
  logic [ITAG_W-1:0]  itag_q;
  logic [DTAG_W-1:0]  dtag_q;
  logic [IWA_W-1:0]   iw_raddr, iw_waddr;
  logic [DWA_W-1:0]   dw_raddr, dw_waddr;
  logic [DATA_W-1:0]  iw_q, dw_q, dw_wdata;

  // address arithmetic
  logic [ADDR_W-1:0]  base0, base1, end_a, cb, bya, vaddr, lastb;
  logic [ADDR_W:0]    end33;
  logic               cach;
  logic [DATA_W-1:0]  size_mask, ins_word, word_sel;
  logic [5:0]         bsh, psh;
  logic [7:0]         rbyte, wbyte;
  logic               dhit_b, lhit, last_pos;
  logic [SIZE_W-1:0]  sz_norm, pos_inc;

  assign acc_in   = in_valid && !in_stall;
  assign in_stall = !(state_r == S_IDLE || state_r == S_WAIT);
  assign out_free = !out_valid_r || !out_stall;

  assign sz_norm = (in_size_bytes == '0) ? SIZE_W'(1) :
                   (in_size_bytes > SIZE_W'(8)) ? SIZE_W'(8) : in_size_bytes;

  assign base0 = addr_r & ~LINE_MASK;
  assign end_a = addr_r + ADDR_W'(sz_r) - ADDR_W'(1);
  assign base1 = end_a & ~LINE_MASK;
  assign cb    = sel_r ? base1 : base0;
  assign bya   = addr_r + ADDR_W'(pos_r);
  assign end33 = {1'b0, addr_r} + (ADDR_W+1)'(sz_r) - (ADDR_W+1)'(1);
  assign lastb = base1 + LINE_MASK;
  assign cach  = !end33[ADDR_W] && (base0 >= lo_r) && (lastb <= hi_r);
  assign vaddr = ((ADDR_W'(vtag_r) << (OFF_W + DIDX_W)) | (ADDR_W'(vidx_r) << OFF_W))
                 + (ADDR_W'(wcnt_r) << 3);

  assign size_mask = {DATA_W{1'b1}} >> (OSIZE_W'(64) - OSIZE_W'({sz_r, 3'b000}));
  assign bsh      = {bya[2:0], 3'b000};
  assign psh      = {pos_r[2:0], 3'b000};
  assign word_sel = (cmd_r == CMD_FETCH) ? iw_q : dw_q;
  assign rbyte    = 8'(word_sel >> bsh);
  assign wbyte    = 8'(data_r >> psh);
  assign ins_word = (dw_q & ~(64'hff << bsh)) | (DATA_W'(wbyte) << bsh);
  assign dhit_b   = dvalid_r[didx_f(bya)] && (dtag_q == dtag_f(bya));
  assign lhit     = (cmd_r == CMD_FETCH) ?
                    (ivalid_r[iidx_f(cb)] && (itag_q == itag_f(cb))) :
                    (dvalid_r[didx_f(cb)] && (dtag_q == dtag_f(cb)));
  assign pos_inc  = pos_r + SIZE_W'(1);
  assign last_pos = (pos_inc == sz_r);

  // ram addressing
  assign itag_raddr = iidx_f(cb);
  assign iw_raddr   = iwa_f(bya);
  assign iw_waddr   = iwa_f(cb) + IWA_W'(wcnt_r);

  always_comb begin
    if (state_r == S_FRD || state_r == S_FCHK) begin
      dtag_raddr = didx_f(addr_r);
    end else if (state_r inside {S_PRD, S_POP, S_CRD, S_COP}) begin
      dtag_raddr = didx_f(bya);
    end else begin
      dtag_raddr = didx_f(cb);
    end
    if (state_r == S_WBRD || state_r == S_WBEM) begin
      dw_raddr = dwa_f(vaddr);
    end else begin
      dw_raddr = dwa_f(bya);
    end
    if (state_r == S_WAIT) begin
      dw_waddr = dwa_f(cb) + DWA_W'(wcnt_r);
      dw_wdata = in_mem_data;
    end else begin
      dw_waddr = dwa_f(bya);
      dw_wdata = ins_word;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    addr_nxt  = addr_r;
    sz_nxt    = sz_r;
    data_nxt  = data_r;
    pos_nxt   = pos_r;
    miss_nxt  = miss_r;
    sel_nxt   = sel_r;
    wk_nxt    = wk_r;
    wcnt_nxt  = wcnt_r;
    vidx_nxt  = vidx_r;
    vtag_nxt  = vtag_r;
    emit      = 1'b0;
    res       = '0;
    iv_we = 1'b0; iv_val = 1'b0; iv_idx = iidx_f(cb);
    dv_we = 1'b0; dv_val = 1'b0; dv_idx = didx_f(cb);
    dd_we = 1'b0; dd_val = 1'b0; dd_idx = didx_f(cb);
    itag_we = 1'b0;
    dtag_we = 1'b0;
    iw_we   = 1'b0;
    dw_we   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (acc_in && in_command <= CMD_FLUSH) begin
          cmd_nxt   = in_command;
          addr_nxt  = in_address;
          sz_nxt    = sz_norm;
          data_nxt  = (in_command inside {CMD_STORE, CMD_COH}) ? in_write_data : '0;
          pos_nxt   = '0;
          miss_nxt  = 1'b0;
          sel_nxt   = 1'b0;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (cmd_r == CMD_FLUSH) begin
          miss_nxt  = 1'b1;
          state_nxt = S_FRD;
        end else if (!cach) begin
          miss_nxt  = 1'b1;
          state_nxt = (cmd_r inside {CMD_STORE, CMD_COH}) ? S_UWR : S_UREQ;
        end else if (cmd_r == CMD_PEEK) begin
          state_nxt = S_PRD;
        end else if (cmd_r == CMD_COH) begin
          state_nxt = S_CRD;
        end else begin
          state_nxt = S_LRD;
        end
      end
      S_UWR: begin
        if (out_free) begin
          emit      = 1'b1;
          res       = '{KIND_WRITE, addr_r, OSIZE_W'(sz_r), data_r & size_mask, 1'b0, 1'b0};
          state_nxt = S_FIN;
        end
      end
      S_UREQ: begin
        if (out_free) begin
          emit      = 1'b1;
          res       = '{KIND_RDREQ, addr_r, OSIZE_W'(sz_r), '0, 1'b0, 1'b1};
          wk_nxt    = WK_UNC;
          state_nxt = S_WAIT;
        end
      end
      S_LRD: begin
        if (sel_r && base1 == base0) begin
          pos_nxt   = '0;
          state_nxt = S_ARD;
        end else begin
          state_nxt = S_LCMP;
        end
      end
      S_LCMP: begin
        if (lhit) begin
          if (sel_r) begin
            pos_nxt   = '0;
            state_nxt = S_ARD;
          end else begin
            sel_nxt   = 1'b1;
            state_nxt = S_LRD;
          end
        end else if (cmd_r == CMD_FETCH) begin
          state_nxt = S_MREQ;
        end else begin
          vidx_nxt  = didx_f(cb);
          vtag_nxt  = dtag_q;
          wcnt_nxt  = '0;
          state_nxt = (dvalid_r[didx_f(cb)] && ddirty_r[didx_f(cb)]) ? S_WBRD : S_MREQ;
        end
      end
      S_MREQ: begin
        if (out_free) begin
          emit = 1'b1;
          res  = '{KIND_RDREQ, cb, OSIZE_W'(LINE_BYTES), '0, 1'b0, 1'b1};
          if (cmd_r == CMD_FETCH) begin
            iv_we  = 1'b1;
            wk_nxt = WK_IFILL;
          end else begin
            dv_we  = 1'b1;
            dd_we  = 1'b1;
            wk_nxt = WK_DFILL;
          end
          miss_nxt  = 1'b1;
          wcnt_nxt  = '0;
          state_nxt = S_WAIT;
        end
      end
      S_WBRD: begin
        state_nxt = S_WBEM;
      end
      S_WBEM: begin
        if (out_free) begin
          emit = 1'b1;
          res  = '{KIND_WRITE, vaddr, OSIZE_W'(8), dw_q, 1'b0, 1'b0};
          if (wcnt_r == LAST_WORD) begin
            dd_we  = 1'b1;
            dd_idx = vidx_r;
            if (cmd_r == CMD_FLUSH) begin
              dv_we     = 1'b1;
              dv_idx    = vidx_r;
              iv_we     = 1'b1;
              iv_idx    = iidx_f(addr_r);
              state_nxt = S_FIN;
            end else begin
              state_nxt = S_MREQ;
            end
          end else begin
            wcnt_nxt  = wcnt_r + CNT_W'(1);
            state_nxt = S_WBRD;
          end
        end
      end
      S_FRD: begin
        state_nxt = S_FCHK;
      end
      S_FCHK: begin
        vidx_nxt = didx_f(addr_r);
        vtag_nxt = dtag_q;
        wcnt_nxt = '0;
        if (dvalid_r[didx_f(addr_r)] && ddirty_r[didx_f(addr_r)]) begin
          state_nxt = S_WBRD;
        end else begin
          dv_we     = 1'b1;
          dv_idx    = didx_f(addr_r);
          dd_we     = 1'b1;
          dd_idx    = didx_f(addr_r);
          iv_we     = 1'b1;
          iv_idx    = iidx_f(addr_r);
          state_nxt = S_FIN;
        end
      end
      S_ARD: begin
        state_nxt = S_AOP;
      end
      S_AOP: begin
        if (cmd_r == CMD_STORE) begin
          dw_we  = 1'b1;
          dd_we  = 1'b1;
          dd_val = 1'b1;
          dd_idx = didx_f(bya);
        end else begin
          data_nxt = data_r | (DATA_W'(rbyte) << psh);
        end
        pos_nxt   = pos_inc;
        state_nxt = last_pos ? S_FIN : S_ARD;
      end
      S_PRD: begin
        state_nxt = S_POP;
      end
      S_POP: begin
        if (dhit_b) begin
          data_nxt  = data_r | (DATA_W'(rbyte) << psh);
          pos_nxt   = pos_inc;
          state_nxt = last_pos ? S_FIN : S_PRD;
        end else if (out_free) begin
          emit      = 1'b1;
          res       = '{KIND_RDREQ, bya, OSIZE_W'(1), '0, 1'b0, 1'b1};
          miss_nxt  = 1'b1;
          wk_nxt    = WK_PEEK;
          state_nxt = S_WAIT;
        end
      end
      S_CRD: begin
        state_nxt = S_COP;
      end
      S_COP: begin
        if (dhit_b) begin
          dw_we     = 1'b1;
          dd_we     = 1'b1;
          dd_val    = 1'b1;
          dd_idx    = didx_f(bya);
          pos_nxt   = pos_inc;
          state_nxt = last_pos ? S_FIN : S_CRD;
        end else if (out_free) begin
          emit      = 1'b1;
          res       = '{KIND_WRITE, bya, OSIZE_W'(1), DATA_W'(wbyte), 1'b0, 1'b0};
          miss_nxt  = 1'b1;
          pos_nxt   = pos_inc;
          state_nxt = last_pos ? S_FIN : S_CRD;
        end
      end
      S_FIN: begin
        if (out_free) begin
          emit = 1'b1;
          if (cmd_r inside {CMD_STORE, CMD_COH, CMD_FLUSH}) begin
            res = '{KIND_DONE, '0, OSIZE_W'(sz_r), '0, !miss_r, 1'b1};
          end else begin
            res = '{KIND_RDATA, '0, OSIZE_W'(sz_r), data_r, !miss_r, 1'b1};
          end
          state_nxt = S_IDLE;
        end
      end
      S_WAIT: begin
        if (acc_in && in_command == CMD_RESP) begin
          case (wk_r)
            WK_IFILL, WK_DFILL: begin
              if (wk_r == WK_IFILL) begin
                iw_we = 1'b1;
              end else begin
                dw_we = 1'b1;
              end
              if (wcnt_r == LAST_WORD) begin
                // line complete, rerun the tag check from the first line
                if (wk_r == WK_IFILL) begin
                  itag_we = 1'b1;
                  iv_we   = 1'b1;
                  iv_val  = 1'b1;
                end else begin
                  dtag_we = 1'b1;
                  dv_we   = 1'b1;
                  dv_val  = 1'b1;
                  dd_we   = 1'b1;
                end
                wk_nxt    = WK_NONE;
                wcnt_nxt  = '0;
                sel_nxt   = 1'b0;
                state_nxt = S_LRD;
              end else begin
                wcnt_nxt = wcnt_r + CNT_W'(1);
              end
            end
            WK_UNC: begin
              data_nxt  = in_mem_data & size_mask;
              wk_nxt    = WK_NONE;
              state_nxt = S_FIN;
            end
            WK_PEEK: begin
              data_nxt  = data_r | (DATA_W'(in_mem_data[7:0]) << psh);
              pos_nxt   = pos_inc;
              wk_nxt    = WK_NONE;
              state_nxt = last_pos ? S_FIN : S_PRD;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wk_r        <= WK_NONE;
      wcnt_r      <= '0;
      sel_r       <= 1'b0;
      miss_r      <= 1'b0;
      pos_r       <= '0;
      ivalid_r    <= '0;
      dvalid_r    <= '0;
      ddirty_r    <= '0;
      out_valid_r <= 1'b0;
      lo_r        <= 32'h8000_0000;
      hi_r        <= 32'h87ff_ffff;
    end else begin
      state_r <= state_nxt;
      wk_r    <= wk_nxt;
      wcnt_r  <= wcnt_nxt;
      sel_r   <= sel_nxt;
      miss_r  <= miss_nxt;
      pos_r   <= pos_nxt;
      if (iv_we) begin
        ivalid_r[iv_idx] <= iv_val;
      end
      if (dv_we) begin
        dvalid_r[dv_idx] <= dv_val;
      end
      if (dd_we) begin
        ddirty_r[dd_idx] <= dd_val;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (psel && penable && pwrite) begin
        if (paddr[2] == REG_LO) begin
          lo_r <= pwdata;
        end else begin
          hi_r <= pwdata;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    addr_r <= addr_nxt;
    sz_r   <= sz_nxt;
    data_r <= data_nxt;
    vidx_r <= vidx_nxt;
    vtag_r <= vtag_nxt;
    if (emit) begin
      res_r <= res;
    end
  end

  dmwc_ram #(.WIDTH(ITAG_W), .DEPTH(ICACHE_LINES)) u_itag (
    .clk(clk), .we(itag_we), .waddr(iidx_f(cb)), .wdata(itag_f(cb)),
    .raddr(itag_raddr), .rdata(itag_q)
  );

  dmwc_ram #(.WIDTH(DTAG_W), .DEPTH(DCACHE_LINES)) u_dtag (
    .clk(clk), .we(dtag_we), .waddr(didx_f(cb)), .wdata(dtag_f(cb)),
    .raddr(dtag_raddr), .rdata(dtag_q)
  );

  dmwc_ram #(.WIDTH(DATA_W), .DEPTH(IWORDS)) u_iword (
    .clk(clk), .we(iw_we), .waddr(iw_waddr), .wdata(in_mem_data),
    .raddr(iw_raddr), .rdata(iw_q)
  );

  dmwc_ram #(.WIDTH(DATA_W), .DEPTH(DWORDS)) u_dword (
    .clk(clk), .we(dw_we), .waddr(dw_waddr), .wdata(dw_wdata),
    .raddr(dw_raddr), .rdata(dw_q)
  );

  assign out_valid   = out_valid_r;
  assign out_kind    = res_r.kind;
  assign out_address = res_r.addr;
  assign out_size    = res_r.size;
  assign out_data    = res_r.data;
  assign out_all_hit = res_r.hit;
  assign out_last    = res_r.last;

  assign prdata = (paddr[2] == REG_LO) ? lo_r : hi_r;
  assign pready = 1'b1;

endmodule

// File: hw/rtl/dmwc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmwc_checker
// Port-level checks for the cache, bound to the top level.
// ----------------------------------------------------------------------------
module dmwc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [dmwc_pkg::KIND_W-1:0]  out_kind,
  input logic [dmwc_pkg::DATA_W-1:0]  out_data,
  input logic                         out_all_hit,
  input logic                         out_last
);
  import dmwc_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data) && $stable(out_kind))
    else $error("stalled result changed");

  // read data and done always close a request
  a_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_RDATA || out_kind == KIND_DONE) |-> out_last)
    else $error("completion not marked last");

  // memory traffic never claims a hit
  a_nohit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_RDREQ || out_kind == KIND_WRITE) |-> !out_all_hit)
    else $error("memory request flagged as hit");

  // reset leaves the block empty and ready
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("not idle after reset");

endmodule

bind direct_mapped_writeback_cache dmwc_checker u_dmwc_checker (.*);

// File: verif/direct_mapped_writeback_cache_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direct_mapped_writeback_cache_checker
// Watches the request, result and register ports of the cache, keeps its own
// copy of both caches and of the access in flight, and compares every result
// with the oldest predicted one.
// ----------------------------------------------------------------------------
module direct_mapped_writeback_cache_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [dmwc_pkg::CMD_W-1:0]   in_command,
  input  logic [dmwc_pkg::ADDR_W-1:0]  in_address,
  input  logic [dmwc_pkg::SIZE_W-1:0]  in_size_bytes,
  input  logic [dmwc_pkg::DATA_W-1:0]  in_write_data,
  input  logic [dmwc_pkg::DATA_W-1:0]  in_mem_data,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [dmwc_pkg::KIND_W-1:0]  out_kind,
  input  logic [dmwc_pkg::ADDR_W-1:0]  out_address,
  input  logic [dmwc_pkg::OSIZE_W-1:0] out_size,
  input  logic [dmwc_pkg::DATA_W-1:0]  out_data,
  input  logic                         out_all_hit,
  input  logic                         out_last,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  input  logic                         pready,
  output int                           fail_count,
  output int                           results_pending,
  output logic                         mem_wait
);
  import dmwc_pkg::*;

  localparam logic [2:0] REG_RANGE_LOW  = 3'd0;
  localparam logic [2:0] REG_RANGE_HIGH = 3'd4;

  logic [31:0] range_lo, range_hi;
  logic        ic_v [64];
  logic [21:0] ic_t [64];
  logic [63:0] ic_w [128];
  logic        dc_v [64];
  logic        dc_d [64];
  logic [21:0] dc_t [64];
  logic [63:0] dc_w [128];

  // access in flight
  logic [2:0]  p_cmd;
  logic [3:0]  p_size;
  logic        p_busy;
  logic [2:0]  p_wait;
  logic [3:0]  p_pos;
  logic        p_sel;
  logic        p_miss;
  logic [31:0] p_addr;
  logic [63:0] p_data;
  int          fill_cnt;

  result_t     expected_results [$];
  int          fails;

  function automatic logic [5:0] ix(input logic [31:0] a);
    return a[9:4];
  endfunction

  function automatic logic [21:0] tg(input logic [31:0] a);
    return a[31:10];
  endfunction

  function automatic logic [31:0] lb(input logic [31:0] a);
    return {a[31:4], 4'b0};
  endfunction

  function automatic logic [63:0] size_mask(input logic [3:0] sz);
    if (sz >= 4'd8) return '1;
    return (64'd1 << (8 * sz)) - 64'd1;
  endfunction

  function automatic logic hit_i(input logic [31:0] a);
    return ic_v[ix(a)] && ic_t[ix(a)] == tg(a);
  endfunction

  function automatic logic hit_d(input logic [31:0] a);
    return dc_v[ix(a)] && dc_t[ix(a)] == tg(a);
  endfunction

  function automatic logic [7:0] byte_i(input logic [31:0] a);
    logic [63:0] w;
    w = ic_w[{ix(a), a[3]}];
    return w[8 * a[2:0] +: 8];
  endfunction

  function automatic logic [7:0] byte_d(input logic [31:0] a);
    logic [63:0] w;
    w = dc_w[{ix(a), a[3]}];
    return w[8 * a[2:0] +: 8];
  endfunction

  function automatic void put_d(input logic [31:0] a, input logic [7:0] b);
    dc_w[{ix(a), a[3]}][8 * a[2:0] +: 8] = b;
    dc_d[ix(a)] = 1'b1;
  endfunction

  function automatic void push_result(input logic [1:0] kind, input logic [31:0] addr,
                                      input logic [6:0] size, input logic [63:0] data,
                                      input logic hit);
    result_t r;
    r.kind = kind;
    r.addr = addr;
    r.size = size;
    r.data = data;
    r.hit  = hit;
    r.last = 1'b0;
    expected_results.push_back(r);
  endfunction

  function automatic void clear_access();
    p_cmd = '0; p_size = '0; p_busy = 1'b0; p_wait = WK_NONE;
    p_pos = '0; p_sel = 1'b0; p_miss = 1'b0;
  endfunction

  function automatic logic cacheable(input logic [31:0] a, input logic [3:0] sz);
    logic [32:0] e;
    e = {1'b0, a} + {29'b0, sz} - 33'd1;
    if (e[32]) return 1'b0;
    if (a < range_lo || e[31:0] > range_hi) return 1'b0;
    if (lb(a) < range_lo) return 1'b0;
    if ({1'b0, lb(e[31:0])} + 33'd15 > {1'b0, range_hi}) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void write_back(input logic [5:0] idx);
    logic [31:0] vb;
    if (!dc_v[idx] || !dc_d[idx]) return;
    vb = {dc_t[idx], idx, 4'b0};
    for (int w = 0; w < 2; w++)
      push_result(KIND_WRITE, vb + 32'(8 * w), 7'd8, dc_w[{idx, w[0]}], 1'b0);
    dc_d[idx] = 1'b0;
  endfunction

  function automatic void advance_cached();
    logic [31:0] a, e, base;
    logic [63:0] acc;
    logic [5:0]  idx;
    a = p_addr;
    e = a + {28'b0, p_size} - 32'd1;
    acc = '0;
    for (int sel = 0; sel < 2; sel++) begin
      base = sel ? lb(e) : lb(a);
      if (sel == 1 && base == lb(a)) break;
      if (p_cmd == CMD_FETCH ? hit_i(base) : hit_d(base)) continue;
      idx = ix(base);
      if (p_cmd == CMD_FETCH) begin
        ic_v[idx] = 1'b0;
        p_wait = WK_IFILL;
      end else begin
        write_back(idx);
        dc_v[idx] = 1'b0;
        dc_d[idx] = 1'b0;
        p_wait = WK_DFILL;
      end
      p_sel = sel[0];
      p_miss = 1'b1;
      fill_cnt = 0;
      push_result(KIND_RDREQ, base, 7'd16, '0, 1'b0);
      return;
    end
    if (p_cmd == CMD_STORE) begin
      for (int i = 0; i < p_size; i++) put_d(a + 32'(i), p_data[8 * i +: 8]);
      push_result(KIND_DONE, '0, {3'b0, p_size}, '0, !p_miss);
    end else begin
      for (int i = 0; i < p_size; i++)
        acc[8 * i +: 8] = p_cmd == CMD_FETCH ? byte_i(a + 32'(i)) : byte_d(a + 32'(i));
      push_result(KIND_RDATA, '0, {3'b0, p_size}, acc, !p_miss);
    end
    clear_access();
  endfunction

  function automatic void advance_peek();
    logic [31:0] b;
    logic [3:0]  pos;
    pos = p_pos;
    while (pos < p_size) begin
      b = p_addr + {28'b0, pos};
      if (!hit_d(b)) begin
        p_pos = pos;
        p_wait = WK_PEEK;
        p_miss = 1'b1;
        push_result(KIND_RDREQ, b, 7'd1, '0, 1'b0);
        return;
      end
      p_data[8 * pos[2:0] +: 8] = p_data[8 * pos[2:0] +: 8] | byte_d(b);
      pos++;
    end
    push_result(KIND_RDATA, '0, {3'b0, p_size}, p_data, !p_miss);
    clear_access();
  endfunction

  function automatic void take_response(input logic [63:0] md);
    logic [31:0] base;
    logic [5:0]  idx;
    case (p_wait)
      WK_IFILL, WK_DFILL: begin
        base = p_sel ? lb(p_addr + {28'b0, p_size} - 32'd1) : lb(p_addr);
        idx = ix(base);
        if (fill_cnt >= 2) fill_cnt = 0;
        if (p_wait == WK_IFILL) ic_w[{idx, fill_cnt[0]}] = md;
        else dc_w[{idx, fill_cnt[0]}] = md;
        fill_cnt++;
        if (fill_cnt < 2) return;
        fill_cnt = 0;
        if (p_wait == WK_IFILL) begin
          ic_v[idx] = 1'b1;
          ic_t[idx] = tg(base);
        end else begin
          dc_v[idx] = 1'b1;
          dc_d[idx] = 1'b0;
          dc_t[idx] = tg(base);
        end
        p_wait = WK_NONE;
        advance_cached();
      end
      WK_UNC: begin
        push_result(KIND_RDATA, '0, {3'b0, p_size}, md & size_mask(p_size), 1'b0);
        clear_access();
      end
      WK_PEEK: begin
        p_data = p_data | ({56'b0, md[7:0]} << (8 * p_pos[2:0]));
        p_pos = p_pos + 4'd1;
        advance_peek();
      end
      default: ;
    endcase
  endfunction

  function automatic void predict_request(input logic [2:0] cmd, input logic [31:0] a,
                                          input logic [3:0] szr, input logic [63:0] wd,
                                          input logic [63:0] md);
    logic [3:0] sz;
    logic       c, hit;
    logic [31:0] b;
    int          start;
    result_t     r;
    sz = szr == 4'd0 ? 4'd1 : (szr > 4'd8 ? 4'd8 : szr);
    start = expected_results.size();
    if (cmd == CMD_RESP) begin
      if (p_busy) take_response(md);
    end else if (!p_busy && cmd < CMD_RESP) begin
      if (cmd <= CMD_PEEK) begin
        c = cacheable(a, sz);
        if (cmd == CMD_STORE && !c) begin
          push_result(KIND_WRITE, a, {3'b0, sz}, wd & size_mask(sz), 1'b0);
          push_result(KIND_DONE, '0, {3'b0, sz}, '0, 1'b0);
        end else begin
          clear_access();
          p_cmd = cmd;
          p_size = sz;
          p_busy = 1'b1;
          p_addr = a;
          p_data = cmd == CMD_STORE ? wd : '0;
          if (!c) begin
            p_wait = WK_UNC;
            push_result(KIND_RDREQ, a, {3'b0, sz}, '0, 1'b0);
          end else if (cmd == CMD_PEEK) advance_peek();
          else advance_cached();
        end
      end else if (cmd == CMD_COH) begin
        if (!cacheable(a, sz)) begin
          push_result(KIND_WRITE, a, {3'b0, sz}, wd & size_mask(sz), 1'b0);
          push_result(KIND_DONE, '0, {3'b0, sz}, '0, 1'b0);
        end else begin
          hit = 1'b1;
          for (int i = 0; i < sz; i++) begin
            b = a + 32'(i);
            if (hit_d(b)) put_d(b, wd[8 * i +: 8]);
            else begin
              push_result(KIND_WRITE, b, 7'd1, {56'b0, wd[8 * i +: 8]}, 1'b0);
              hit = 1'b0;
            end
          end
          push_result(KIND_DONE, '0, {3'b0, sz}, '0, hit);
        end
      end else begin
        write_back(ix(a));
        dc_v[ix(a)] = 1'b0;
        dc_d[ix(a)] = 1'b0;
        dc_t[ix(a)] = '0;
        ic_v[ix(a)] = 1'b0;
        ic_t[ix(a)] = '0;
        push_result(KIND_DONE, '0, {3'b0, sz}, '0, 1'b0);
      end
    end
    if (expected_results.size() > start) begin
      r = expected_results.pop_back();
      r.last = 1'b1;
      expected_results.push_back(r);
    end
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
    fails++;
  endtask

  always @(posedge clk) begin
    result_t e;
    if (!rst_n) begin
      fails = 0;
      range_lo = 32'h8000_0000;
      range_hi = 32'h87ff_ffff;
      for (int i = 0; i < 64; i++) begin
        ic_v[i] = 1'b0; ic_t[i] = '0; dc_v[i] = 1'b0; dc_d[i] = 1'b0; dc_t[i] = '0;
      end
      for (int i = 0; i < 128; i++) begin
        ic_w[i] = '0; dc_w[i] = '0;
      end
      clear_access();
      p_addr = '0;
      p_data = '0;
      fill_cnt = 0;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) report("unexpected result", out_data, '0);
        else begin
          e = expected_results.pop_front();
          if (out_kind != e.kind) report("kind", 64'(out_kind), 64'(e.kind));
          if (out_address != e.addr) report("address", 64'(out_address), 64'(e.addr));
          if (out_size != e.size) report("size", 64'(out_size), 64'(e.size));
          if (out_data != e.data) report("data", out_data, e.data);
          if (out_all_hit != e.hit) report("all_hit", 64'(out_all_hit), 64'(e.hit));
          if (out_last != e.last) report("last", 64'(out_last), 64'(e.last));
        end
      end
      if (in_valid && !in_stall)
        predict_request(in_command, in_address, in_size_bytes, in_write_data, in_mem_data);
      if (psel && penable && pwrite && pready) begin
        if (paddr == REG_RANGE_LOW) range_lo = pwdata;
        else if (paddr == REG_RANGE_HIGH) range_hi = pwdata;
      end
    end
    fail_count <= fails;
    results_pending <= expected_results.size();
    mem_wait <= p_busy;
  end

endmodule

// File: verif/direct_mapped_writeback_cache_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direct_mapped_writeback_cache_test
// Drives fetches, loads, stores, peeks, coherent writes, flushes and memory
// responses into the cache under several cacheable ranges, answers its
// memory read requests, and stalls both sides at random.
// ----------------------------------------------------------------------------
module direct_mapped_writeback_cache_test;
  import dmwc_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE = 3'd7;
  localparam logic [2:0] REG_RANGE_LOW  = 3'd0;
  localparam logic [2:0] REG_RANGE_HIGH = 3'd4;
  localparam int IDLE_LIMIT = 4000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [CMD_W-1:0]   in_command = '0;
  logic [ADDR_W-1:0]  in_address = '0;
  logic [SIZE_W-1:0]  in_size_bytes = '0;
  logic [DATA_W-1:0]  in_write_data = '0;
  logic [DATA_W-1:0]  in_mem_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [KIND_W-1:0]  out_kind;
  logic [ADDR_W-1:0]  out_address;
  logic [OSIZE_W-1:0] out_size;
  logic [DATA_W-1:0]  out_data;
  logic               out_all_hit;
  logic               out_last;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  int          fail_count, results_pending;
  logic        mem_wait;
  int          tx_idle = 38, rx_idle = 46;
  int          sent = 0;
  int          quiet_cycles = 0;
  logic [31:0] win_base = 32'h8000_0000;

  always #5 clk = ~clk;

  direct_mapped_writeback_cache u_dut (.*);

  direct_mapped_writeback_cache_checker u_chk (.*);

  always @(posedge clk) out_stall <= $urandom_range(99) < rx_idle;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_request(input logic [2:0] cmd, input logic [31:0] a,
                              input logic [3:0] sz, input logic [63:0] wd,
                              input logic [63:0] md);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_address    <= a;
    in_size_bytes <= sz;
    in_write_data <= wd;
    in_mem_data   <= md;
    do @(posedge clk); while (in_stall);
    sent++;
    if (sent == 110) begin
      tx_idle = 46; rx_idle = 38;
    end else if (sent == 220) begin
      tx_idle = 0; rx_idle = 0;
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_response();
    send_request(CMD_RESP, $urandom, 4'($urandom), rand64(), rand64());
  endtask

  // answer memory read requests until nothing is outstanding
  task automatic drain();
    in_valid <= 1'b0;
    forever begin
      @(posedge clk);
      if (results_pending == 0 && !mem_wait) break;
      if (results_pending == 0 && mem_wait) begin
        send_response();
        in_valid <= 1'b0;
      end
    end
  endtask

  task automatic directed(input logic [2:0] cmd, input logic [31:0] a,
                          input logic [3:0] sz, input logic [63:0] wd);
    send_request(cmd, a, sz, wd, rand64());
    drain();
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_range(input logic [31:0] lo, input logic [31:0] hi,
                           input logic [31:0] base);
    drain();
    repeat (60) @(posedge clk);
    reg_write(REG_RANGE_LOW, lo);
    reg_write(REG_RANGE_HIGH, hi);
    win_base = base;
  endtask

  // few tags over few indexes so that lines hit, conflict and get evicted
  function automatic logic [31:0] pick_address();
    int r;
    r = $urandom_range(99);
    if (r < 70)
      return win_base + ($urandom_range(3) << 10) + ($urandom_range(7) << 4)
             + $urandom_range(15);
    if (r < 80) return win_base - 8 + $urandom_range(16);
    if (r < 90) return 32'hffff_fff0 + $urandom_range(15);
    return $urandom;
  endfunction

  function automatic logic [3:0] pick_size();
    if ($urandom_range(9) == 0) return 4'($urandom_range(15));
    return 4'($urandom_range(8, 1));
  endfunction

  task automatic random_phase(input int count);
    int r;
    logic [2:0] cmd;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (mem_wait && r < 85) send_response();
      else begin
        if (r < 4) cmd = CMD_RESP;
        else if (r < 6) cmd = CMD_SPARE;
        else cmd = 3'($urandom_range(5));
        send_request(cmd, pick_address(), pick_size(), rand64(), rand64());
      end
      // mostly let the request finish so the next one sees a settled cache
      if ($urandom_range(99) < 70) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0) @(posedge clk);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed(CMD_RESP, 32'h8000_0000, 4'd8, '0);
    directed(CMD_FETCH, 32'h8000_0000, 4'd8, '0);
    directed(CMD_FETCH, 32'h8000_0004, 4'd4, '0);
    directed(CMD_FETCH, 32'h8000_001c, 4'd8, '0);
    directed(CMD_LOAD, 32'h8000_0100, 4'd0, '0);
    directed(CMD_STORE, 32'h8000_0100, 4'd15, '1);
    directed(CMD_LOAD, 32'h8000_0100, 4'd8, '0);
    directed(CMD_STORE, 32'h8000_010c, 4'd8, 64'h0123_4567_89ab_cdef);
    directed(CMD_FETCH, 32'h8000_0100, 4'd8, '0);
    directed(CMD_LOAD, 32'h8000_0500, 4'd4, '0);
    directed(CMD_PEEK, 32'h8000_050c, 4'd8, '0);
    directed(CMD_COH, 32'h8000_050e, 4'd8, '1);
    directed(CMD_FLUSH, 32'h8000_0500, 4'd1, '0);
    directed(CMD_LOAD, 32'h0000_0000, 4'd8, '0);
    directed(CMD_STORE, 32'hffff_ffff, 4'd8, '1);
    directed(CMD_COH, 32'h0000_0000, 4'd2, '1);
    directed(CMD_PEEK, 32'hffff_fffc, 4'd8, '0);
    directed(CMD_SPARE, 32'h8000_0000, 4'd8, '1);
    directed(CMD_LOAD, 32'h87ff_fffc, 4'd8, '0);
    // a request while a memory response is still awaited is dropped
    send_request(CMD_LOAD, 32'h8000_0700, 4'd8, '0, '0);
    send_request(CMD_STORE, 32'h8000_0700, 4'd8, '1, '0);
    drain();

    random_phase(40);
    set_range(32'h0000_0000, 32'hffff_ffff, 32'hffff_f800);
    random_phase(40);
    set_range(32'h8000_0008, 32'h8000_07f7, 32'h8000_0000);
    random_phase(40);
    set_range(32'hffff_ffff, 32'h0000_0000, 32'h8000_0000);
    random_phase(24);
    set_range(32'h0000_0000, 32'h0000_07ff, 32'h0000_0000);
    random_phase(40);
    set_range(32'h8000_0000, 32'h87ff_ffff, 32'h8000_0000);
    random_phase(16);

    drain();
    repeat (80) @(posedge clk);
    if (fail_count == 0 && results_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
